// ===== rtl/core/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants for the cartridge bank mapper
// Memory target codes, control register selectors and the bundles passed
// between the translation logic and the control register block.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int ADDR_W      = 16;
	localparam int DATA_W      = 8;
	localparam int PHYS_W      = 21;
	localparam int ROM_BANK_W  = 7;
	localparam int RAM_BANK_W  = 2;
	localparam int LOW_BANK_W  = 5;
	localparam int ROM_OFS_W   = 14;
	localparam int RAM_OFS_W   = 13;
	localparam int CFG_IDX_W   = 1;

	// Reset values of the mask registers
	localparam logic [ROM_BANK_W-1:0] ROM_MASK_RST = 7'h7F;
	localparam logic [RAM_BANK_W-1:0] RAM_MASK_RST = 2'h3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_MASK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_MASK = 1'b1;

	// Address pages (address bits 15..12) of the RAM window
	localparam logic [3:0] PAGE_RAM_A = 4'hA;
	localparam logic [3:0] PAGE_RAM_B = 4'hB;

	// Low nibble that switches RAM on
	localparam logic [3:0] RAM_EN_KEY = 4'hA;

	// Access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Control register selected by address bits 14..13 of a control write
	localparam logic [1:0] CTL_RAM_EN   = 2'd0;
	localparam logic [1:0] CTL_ROM_LOW  = 2'd1;
	localparam logic [1:0] CTL_UPPER    = 2'd2;
	localparam logic [1:0] CTL_MODE     = 2'd3;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_ROM  = 2'd1,
		TGT_RAM  = 2'd2
	} target_t;

	// Banking state seen by the translation logic
	typedef struct packed {
		logic                  ram_enable;
		logic [LOW_BANK_W-1:0] rom_bank_low;
		logic [1:0]            bank_upper;
		logic                  bank_mode;
		logic [ROM_BANK_W-1:0] rom_bank_mask;
		logic [RAM_BANK_W-1:0] ram_bank_mask;
	} bank_state_t;

	// Control register write request from the translation logic
	typedef struct packed {
		logic              en;
		logic [1:0]        sel;
		logic [DATA_W-1:0] data;
	} ctl_wr_t;

endpackage

// ===== rtl/core/cbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbm_ctrl: banking control registers
// Holds RAM enable, ROM bank low bits, upper bank bits, banking mode and
// the two bank mask registers written over the configuration port.
// ----------------------------------------------------------------------------
module cbm_ctrl (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cbm_pkg::ctl_wr_t                      ctl_wr,
	input  logic                                  cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cbm_pkg::ROM_BANK_W-1:0]        cfg_data,
	output cbm_pkg::bank_state_t                  state
);
	import cbm_pkg::*;

	logic                  ram_enable_q;
	logic [LOW_BANK_W-1:0] rom_bank_low_q;
	logic [1:0]            bank_upper_q;
	logic                  bank_mode_q;
	logic [ROM_BANK_W-1:0] rom_mask_q;
	logic [RAM_BANK_W-1:0] ram_mask_q;
	logic [LOW_BANK_W-1:0] low_wr;

	// A zero written to the ROM bank low bits is stored as bank 1
	assign low_wr = (ctl_wr.data[LOW_BANK_W-1:0] == '0) ?
		LOW_BANK_W'(1) : ctl_wr.data[LOW_BANK_W-1:0];

	// Control state written by bus transactions below 0x8000
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enable_q   <= 1'b0;
			rom_bank_low_q <= LOW_BANK_W'(1);
			bank_upper_q   <= 2'd0;
			bank_mode_q    <= 1'b0;
		end else if (ctl_wr.en) begin
			case (ctl_wr.sel)
				CTL_RAM_EN:  ram_enable_q   <= (ctl_wr.data[3:0] == RAM_EN_KEY);
				CTL_ROM_LOW: rom_bank_low_q <= low_wr;
				CTL_UPPER:   bank_upper_q   <= ctl_wr.data[1:0];
				CTL_MODE:    bank_mode_q    <= ctl_wr.data[0];
				default:     bank_mode_q    <= bank_mode_q;
			endcase
		end
	end

	// Mask registers from the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mask_q <= ROM_MASK_RST;
			ram_mask_q <= RAM_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROM_MASK: rom_mask_q <= cfg_data;
				CFG_RAM_MASK: ram_mask_q <= cfg_data[RAM_BANK_W-1:0];
				default:      rom_mask_q <= rom_mask_q;
			endcase
		end
	end

	assign state.ram_enable    = ram_enable_q;
	assign state.rom_bank_low  = rom_bank_low_q;
	assign state.bank_upper    = bank_upper_q;
	assign state.bank_mode     = bank_mode_q;
	assign state.rom_bank_mask = rom_mask_q;
	assign state.ram_bank_mask = ram_mask_q;

endmodule

// ===== rtl/core/cbm_xlate.sv =====
// ----------------------------------------------------------------------------
// cbm_xlate: bus access translation
// Decodes the page of one access, forms the physical ROM or RAM address,
// gates RAM writes and raises control register writes.
// ----------------------------------------------------------------------------
module cbm_xlate (
	input  logic                               op,
	input  logic [cbm_pkg::ADDR_W-1:0]         address,
	input  logic [cbm_pkg::DATA_W-1:0]         data,
	input  cbm_pkg::bank_state_t               state,
	output cbm_pkg::target_t                   target,
	output logic [cbm_pkg::PHYS_W-1:0]         phys_addr,
	output logic                               ram_write,
	output logic [cbm_pkg::DATA_W-1:0]         write_data,
	output cbm_pkg::ctl_wr_t                   ctl_wr
);
	import cbm_pkg::*;

	logic [3:0]            page;
	logic [ROM_BANK_W-1:0] sw_bank;
	logic [RAM_BANK_W-1:0] ram_bank;

	assign page = address[ADDR_W-1:ADDR_W-4];

	// Switchable ROM bank: upper bits joined above in mode 1
	assign sw_bank = {(state.bank_mode ? state.bank_upper : 2'd0), state.rom_bank_low}
		& state.rom_bank_mask;
	assign ram_bank = state.bank_upper & state.ram_bank_mask;

	always_comb begin
		target     = TGT_NONE;
		phys_addr  = '0;
		ram_write  = 1'b0;
		write_data = '0;
		ctl_wr.en   = 1'b0;
		ctl_wr.sel  = address[14:13];
		ctl_wr.data = data;
		if (page == PAGE_RAM_A || page == PAGE_RAM_B) begin
			// Cartridge RAM window, writes only while enabled
			target    = TGT_RAM;
			phys_addr = PHYS_W'({ram_bank, address[RAM_OFS_W-1:0]});
			if (op == OP_WRITE && state.ram_enable) begin
				ram_write  = 1'b1;
				write_data = data;
			end
		end else if (!page[3]) begin
			if (op == OP_WRITE) begin
				ctl_wr.en = 1'b1;
			end else if (!page[2]) begin
				target    = TGT_ROM;
				phys_addr = PHYS_W'(address[ROM_OFS_W-1:0]);
			end else begin
				target    = TGT_ROM;
				phys_addr = {sw_bank, address[ROM_OFS_W-1:0]};
			end
		end
	end

endmodule

// ===== rtl/core/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: cartridge ROM/RAM bank controller
// Each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while the result stream is not stalled,
// set by the single pass of decode logic between the two registers.
// Reset: RAM disabled, switchable ROM bank 1, upper bits and mode 0, masks
// all ones; both pipeline stages empty.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // address[15:0], data[23:16]
	input  logic [0:0]  s_axis_tuser,  // op[0]
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // phys_addr[20:0], write_data[28:21], zero[31:29]
	output logic [2:0]  m_axis_tuser,  // target[1:0], ram_write[2]
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import cbm_pkg::*;

	logic              valid_s1;
	logic              op_s1;
	logic [ADDR_W-1:0] address_s1;
	logic [DATA_W-1:0] data_s1;

	logic              valid_s2;
	target_t           target_s2;
	logic [PHYS_W-1:0] phys_s2;
	logic              ram_write_s2;
	logic [DATA_W-1:0] wdata_s2;

	target_t           target_c;
	logic [PHYS_W-1:0] phys_c;
	logic              ram_write_c;
	logic [DATA_W-1:0] wdata_c;
	ctl_wr_t           ctl_wr_c;
	ctl_wr_t           ctl_wr;
	bank_state_t       state;
	logic              adv_s1;

	// Stage 1 moves on when the result register is free or being drained
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign cfg_ready     = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1      <= s_axis_tuser[0];
			address_s1 <= s_axis_tdata[ADDR_W-1:0];
			data_s1    <= s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
		end
	end

	cbm_xlate u_xlate (
		.op         (op_s1),
		.address    (address_s1),
		.data       (data_s1),
		.state      (state),
		.target     (target_c),
		.phys_addr  (phys_c),
		.ram_write  (ram_write_c),
		.write_data (wdata_c),
		.ctl_wr     (ctl_wr_c)
	);

	// Control writes take effect as the transaction leaves stage 1
	always_comb begin
		ctl_wr    = ctl_wr_c;
		ctl_wr.en = ctl_wr_c.en && adv_s1;
	end

	cbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_wr    (ctl_wr),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.state     (state)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			target_s2    <= target_c;
			phys_s2      <= phys_c;
			ram_write_s2 <= ram_write_c;
			wdata_s2     <= wdata_c;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, wdata_s2, phys_s2};
	assign m_axis_tuser  = {ram_write_s2, target_s2};

	// A RAM write is only ever issued towards cartridge RAM
	a_wr_is_ram: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ram_write_s2 |-> target_s2 == TGT_RAM)
		else $error("ram_write raised outside the RAM target");

	// No memory selected means a zero address and no data
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && target_s2 == TGT_NONE |-> phys_s2 == '0 && wdata_s2 == '0)
		else $error("non-zero payload on an unmapped result");

	// The switchable ROM low bits never hold bank zero
	a_low_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state.rom_bank_low != '0)
		else $error("rom_bank_low reached zero");

	// A stalled stage 1 transaction is kept
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(address_s1))
		else $error("stage 1 transaction lost while stalled");

	// Control writes never leave stage 1 while the result register is blocked
	a_ctl_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_axis_tready |-> !ctl_wr.en)
		else $error("control write applied during a stall");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the cartridge bank mapper
// Drives bus accesses and mask register writes into the mapper. A local
// model of the banking state works out the expected translation of every
// accepted access. Each translation from the result stream is checked field
// by field against the oldest outstanding expectation. Both stream sides
// idle at random, with runs of back-to-back transactions between.
// ----------------------------------------------------------------------------
module testbench;
	import cbm_pkg::*;

	localparam int SETTLE_CYCLES = 4;       // result path is two registers deep
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 230;

	// One queued stimulus entry: a bus access or a mask register write
	typedef struct {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [ROM_BANK_W-1:0] val;
		logic                  op;
		logic [ADDR_W-1:0]     addr;
		logic [DATA_W-1:0]     data;
	} bus_item_t;

	// Expected translation of one access
	typedef struct {
		target_t           tgt;
		logic [PHYS_W-1:0] phys;
		logic              wr;
		logic [DATA_W-1:0] wdata;
	} xlat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // address[15:0], data[23:16]
	logic [0:0]  s_axis_tuser = '0;   // op[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // phys_addr[20:0], write_data[28:21], zero[31:29]
	logic [2:0]  m_axis_tuser;        // target[1:0], ram_write[2]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = CFG_ROM_MASK;
	logic [6:0]  cfg_data = '0;

	bus_item_t access_q[$];
	xlat_t     xlat_q[$];

	// Banking model state
	logic                  mdl_ram_en;
	logic [LOW_BANK_W-1:0] mdl_rom_low;
	logic [1:0]            mdl_upper;
	logic                  mdl_mode;
	logic [ROM_BANK_W-1:0] mdl_rom_mask;
	logic [RAM_BANK_W-1:0] mdl_ram_mask;

	int mismatch_count = 0;
	int cycle_count = 0;
	int feed_gap = 0;
	int sink_hold = 0;
	int idle_cycles = 0;
	bit src_calm = 1'b0;
	bit sink_calm = 1'b0;

	cartridge_bank_mapper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Translate one access and update the banking state it touches
	function automatic xlat_t translate_access(input logic op, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		xlat_t                 r;
		logic [3:0]            page;
		logic [RAM_BANK_W-1:0] ram_bank;
		logic [ROM_BANK_W-1:0] rom_bank;
		page = addr[15:12];
		r.tgt = TGT_NONE;
		r.phys = '0;
		r.wr = 1'b0;
		r.wdata = '0;
		if (page == PAGE_RAM_A || page == PAGE_RAM_B) begin
			ram_bank = mdl_upper & mdl_ram_mask;
			r.tgt = TGT_RAM;
			r.phys = {6'b0, ram_bank, addr[RAM_OFS_W-1:0]};
			if (op == OP_WRITE && mdl_ram_en) begin
				r.wr = 1'b1;
				r.wdata = data;
			end
		end else if (!addr[15]) begin
			if (op == OP_WRITE) begin
				// control write, register picked by address bits 14..13
				case (addr[14:13])
					CTL_RAM_EN: mdl_ram_en = (data[3:0] == RAM_EN_KEY);
					CTL_ROM_LOW: mdl_rom_low = (data[4:0] == '0) ? 5'd1 : data[4:0];
					CTL_UPPER: mdl_upper = data[1:0];
					default: mdl_mode = data[0];
				endcase
			end else if (!addr[14]) begin
				r.tgt = TGT_ROM;
				r.phys = {7'b0, addr[ROM_OFS_W-1:0]};
			end else begin
				rom_bank = {(mdl_mode ? mdl_upper : 2'b00), mdl_rom_low} & mdl_rom_mask;
				r.tgt = TGT_ROM;
				r.phys = {rom_bank, addr[ROM_OFS_W-1:0]};
			end
		end
		return r;
	endfunction

	// Source gaps: runs of back-to-back items alternate with gappy runs
	function automatic int draw_src_gap();
		if ($urandom_range(0, 31) == 0)
			src_calm = !src_calm;
		return src_calm ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic int draw_sink_stall();
		if ($urandom_range(0, 31) == 0)
			sink_calm = !sink_calm;
		return sink_calm ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic push_access(input logic op, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		bus_item_t it;
		it.is_cfg = 1'b0;
		it.idx = CFG_ROM_MASK;
		it.val = '0;
		it.op = op;
		it.addr = addr;
		it.data = data;
		access_q.insert(access_q.size(), it);
	endtask

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ROM_BANK_W-1:0] val);
		bus_item_t it;
		it.is_cfg = 1'b1;
		it.idx = idx;
		it.val = val;
		it.op = OP_READ;
		it.addr = '0;
		it.data = '0;
		access_q.insert(access_q.size(), it);
	endtask

	// Random access, biased towards control writes and banked windows
	task automatic push_random_access();
		int                r;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		r = $urandom_range(0, 99);
		a = ADDR_W'($urandom);
		d = DATA_W'($urandom);
		if (r < 30) begin
			a[15] = 1'b0;
			if (a[14:13] == CTL_RAM_EN && $urandom_range(0, 1) == 1)
				d[3:0] = RAM_EN_KEY;
			else if (a[14:13] == CTL_ROM_LOW && $urandom_range(0, 3) == 0)
				d[4:0] = '0;
			push_access(OP_WRITE, a, d);
		end else if (r < 55) begin
			a[15] = 1'b0;
			push_access(OP_READ, a, d);
		end else if (r < 85) begin
			a[15:13] = 3'b101;
			push_access(1'($urandom_range(0, 1)), a, d);
		end else begin
			push_access(1'($urandom_range(0, 1)), a, d);
		end
	endtask

	// Source side: feeds accesses and mask writes from the queue
	always @(posedge clk or negedge arst_n) begin : feed
		bus_item_t head;
		logic      n_valid;
		logic      n_cfg;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= CFG_ROM_MASK;
			cfg_data <= '0;
			feed_gap = 0;
			idle_cycles = 0;
			mdl_ram_en = 1'b0;
			mdl_rom_low = 5'd1;
			mdl_upper = 2'b00;
			mdl_mode = 1'b0;
			mdl_rom_mask = ROM_MASK_RST;
			mdl_ram_mask = RAM_MASK_RST;
		end else begin
			n_valid = s_axis_tvalid;
			n_cfg = cfg_valid;
			if (s_axis_tvalid && s_axis_tready) begin
				xlat_q.insert(xlat_q.size(), translate_access(s_axis_tuser[0],
					s_axis_tdata[15:0], s_axis_tdata[23:16]));
				head = access_q.pop_front();
				n_valid = 1'b0;
				feed_gap = draw_src_gap();
			end
			if (cfg_valid && cfg_ready) begin
				head = access_q.pop_front();
				if (head.idx == CFG_ROM_MASK)
					mdl_rom_mask = head.val;
				else
					mdl_ram_mask = head.val[RAM_BANK_W-1:0];
				n_cfg = 1'b0;
			end
			// cycles with nothing in flight, for mask writes
			if (xlat_q.size() != 0 || n_valid || (s_axis_tvalid && s_axis_tready))
				idle_cycles = 0;
			else if (idle_cycles < SETTLE_CYCLES)
				idle_cycles++;
			if (!n_valid && !n_cfg) begin
				if (feed_gap != 0) begin
					feed_gap--;
				end else if (access_q.size() != 0) begin
					head = access_q[0];
					if (!head.is_cfg) begin
						n_valid = 1'b1;
						s_axis_tdata <= {head.data, head.addr};
						s_axis_tuser <= head.op;
					end else if (idle_cycles >= SETTLE_CYCLES) begin
						n_cfg = 1'b1;
						cfg_index <= head.idx;
						cfg_data <= head.val;
					end
				end
			end
			s_axis_tvalid <= n_valid;
			cfg_valid <= n_cfg;
		end
	end

	task automatic report_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Result side: random stalls, every transaction checked in order
	always @(posedge clk or negedge arst_n) begin : sink
		xlat_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_hold = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (xlat_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
						$time, m_axis_tdata, m_axis_tuser);
					mismatch_count++;
				end else begin
					want = xlat_q.pop_front();
					report_field("target", want.tgt, m_axis_tuser[1:0]);
					report_field("phys_addr", want.phys, m_axis_tdata[20:0]);
					report_field("ram_write", want.wr, m_axis_tuser[2]);
					report_field("write_data", want.wdata, m_axis_tdata[28:21]);
				end
				sink_hold = draw_sink_stall();
			end else if (sink_hold != 0) begin
				sink_hold--;
			end
			m_axis_tready <= (sink_hold == 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		logic [ROM_BANK_W-1:0] rom_set;
		logic [ROM_BANK_W-1:0] ram_set;
		// directed: reset state, disabled RAM, bank zero fix-up, mode 1, unmapped pages
		push_access(OP_READ, 16'h0000, 8'h00);
		push_access(OP_READ, 16'h7FFF, 8'hFF);
		push_access(OP_WRITE, 16'hA000, 8'hFF);
		push_access(OP_READ, 16'hBFFF, 8'h00);
		push_access(OP_WRITE, 16'h0000, 8'h0A);
		push_access(OP_WRITE, 16'hBFFF, 8'h5A);
		push_access(OP_WRITE, 16'h2000, 8'h00);
		push_access(OP_READ, 16'h4000, 8'h00);
		push_access(OP_WRITE, 16'h3FFF, 8'hFF);
		push_access(OP_WRITE, 16'h4000, 8'h03);
		push_access(OP_READ, 16'h7FFF, 8'h00);
		push_access(OP_WRITE, 16'h6000, 8'h01);
		push_access(OP_READ, 16'h4000, 8'h00);
		push_access(OP_READ, 16'h3FFF, 8'h00);
		push_access(OP_READ, 16'hA000, 8'h00);
		push_access(OP_READ, 16'h8000, 8'hFF);
		push_access(OP_WRITE, 16'h9FFF, 8'hFF);
		push_access(OP_WRITE, 16'hC000, 8'h55);
		push_access(OP_READ, 16'hFFFF, 8'hFF);
		push_access(OP_WRITE, 16'h1FFF, 8'hFB);
		push_access(OP_WRITE, 16'hA123, 8'h77);
		push_access(OP_WRITE, 16'h2000, 8'hE0);
		push_access(OP_WRITE, 16'h7FFF, 8'hFE);
		push_access(OP_WRITE, 16'h5000, 8'hFC);
		push_access(OP_READ, 16'h6ABC, 8'h00);

		// mask settings: both extremes first, then a spread, then random
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin rom_set = 7'h00; ram_set = 7'h00; end
				1: begin rom_set = 7'h7F; ram_set = 7'h03; end
				2: begin rom_set = 7'h01; ram_set = 7'h7E; end
				3: begin rom_set = 7'h3F; ram_set = 7'h01; end
				4: begin rom_set = 7'h1F; ram_set = 7'h7F; end
				5: begin rom_set = 7'h0F; ram_set = 7'h02; end
				default: begin
					rom_set = ROM_BANK_W'($urandom);
					ram_set = ROM_BANK_W'($urandom);
				end
			endcase
			push_cfg(CFG_ROM_MASK, rom_set);
			push_cfg(CFG_RAM_MASK, ram_set);
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_random_access();
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (access_q.size() != 0 || xlat_q.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cbm_pkg.sv
rtl/core/cbm_ctrl.sv
rtl/core/cbm_xlate.sv
rtl/core/cartridge_bank_mapper.sv
tb/testbench.sv
